### rtl/core/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and constants for the three-wire serial master.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned CNT_W         = 4;

  // action codes on the input channel
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CMD,
    PH_WDATA,
    PH_RDATA
  } phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] command_byte;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
  } result_t;

endpackage

### rtl/core/tws_in_stage.sv
// ----------------------------------------------------------------------------
// tws_in_stage
// Input register: captures one item per cycle and holds it while the
// engine cannot take it.
// ----------------------------------------------------------------------------
module tws_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  tws_pkg::item_t in_item,
  input  logic           take,
  output logic           item_valid,
  output tws_pkg::item_t item
);
  import tws_pkg::*;

  assign in_stall = item_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_item;
    end
  end

endmodule

### rtl/core/tws_engine.sv
// ----------------------------------------------------------------------------
// tws_engine
// Transaction state machine: one half period of the serial clock per item,
// computing the next line levels and the result in a single pass.
// ----------------------------------------------------------------------------
module tws_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  tws_pkg::item_t   item,
  output tws_pkg::result_t result
);
  import tws_pkg::*;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] bit_count, bit_count_next;
  logic             half_step, half_step_next;
  logic [7:0]       tx_shift, tx_shift_next;
  logic [7:0]       pending_data, pending_data_next;
  logic [7:0]       rx_shift, rx_shift_next;
  logic             is_read, is_read_next;
  logic             ce, ce_next;
  logic             sclk, sclk_next;
  logic             dat, dat_next;
  logic             valid_next;
  logic             drive;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= '0;
      half_step    <= 1'b0;
      tx_shift     <= '0;
      pending_data <= '0;
      rx_shift     <= '0;
      is_read      <= 1'b0;
      ce           <= 1'b0;
      sclk         <= 1'b0;
      dat          <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      half_step    <= half_step_next;
      tx_shift     <= tx_shift_next;
      pending_data <= pending_data_next;
      rx_shift     <= rx_shift_next;
      is_read      <= is_read_next;
      ce           <= ce_next;
      sclk         <= sclk_next;
      dat          <= dat_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    half_step_next    = half_step;
    tx_shift_next     = tx_shift;
    pending_data_next = pending_data;
    rx_shift_next     = rx_shift;
    is_read_next      = is_read;
    ce_next           = ce;
    sclk_next         = sclk;
    dat_next          = dat;
    valid_next        = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (item.action == ACT_WRITE || item.action == ACT_READ) begin
          is_read_next      = (item.action == ACT_READ);
          pending_data_next = item.write_data;
          tx_shift_next     = item.command_byte;
          rx_shift_next     = '0;
          bit_count_next    = '0;
          phase_next        = PH_CMD;
          ce_next           = 1'b1;
          sclk_next         = 1'b0;
          dat_next          = item.command_byte[0];
          half_step_next    = 1'b0;
        end
      end
      PH_CMD, PH_WDATA: begin
        priority if (!half_step) begin
          sclk_next      = 1'b1;
          half_step_next = 1'b1;
          bit_count_next = bit_count + 1'b1;
        end else if (bit_count < CNT_W'(BITS_PER_BYTE)) begin
          tx_shift_next  = {1'b0, tx_shift[7:1]};
          sclk_next      = 1'b0;
          dat_next       = tx_shift[1];
          half_step_next = 1'b0;
        end else if (phase == PH_CMD && !is_read) begin
          phase_next     = PH_WDATA;
          tx_shift_next  = pending_data;
          bit_count_next = '0;
          sclk_next      = 1'b0;
          dat_next       = pending_data[0];
          half_step_next = 1'b0;
        end else if (phase == PH_CMD) begin
          // release the line and take the first read bit on this clock fall
          phase_next     = PH_RDATA;
          dat_next       = 1'b0;
          sclk_next      = 1'b0;
          rx_shift_next  = {item.sda_in, rx_shift[7:1]};
          bit_count_next = CNT_W'(1);
          half_step_next = 1'b0;
        end else begin
          sclk_next      = 1'b1;
          ce_next        = 1'b0;
          phase_next     = PH_IDLE;
          half_step_next = 1'b0;
          bit_count_next = '0;
        end
      end
      PH_RDATA: begin
        priority if (half_step) begin
          sclk_next      = 1'b0;
          rx_shift_next  = {item.sda_in, rx_shift[7:1]};
          bit_count_next = bit_count + 1'b1;
          half_step_next = 1'b0;
        end else if (bit_count >= CNT_W'(BITS_PER_BYTE)) begin
          sclk_next      = 1'b1;
          ce_next        = 1'b0;
          phase_next     = PH_IDLE;
          half_step_next = 1'b0;
          bit_count_next = '0;
          valid_next     = 1'b1;
        end else begin
          sclk_next      = 1'b1;
          half_step_next = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    drive               = (phase_next == PH_CMD) || (phase_next == PH_WDATA);
    result.chip_enable  = ce_next;
    result.serial_clock = sclk_next;
    result.sda_out      = drive && dat_next;
    result.sda_drive    = drive;
    result.busy_res     = (phase_next != PH_IDLE);
    result.read_valid   = valid_next;
    result.read_data    = rx_shift_next;
  end

endmodule

### rtl/core/tws_out_stage.sv
// ----------------------------------------------------------------------------
// tws_out_stage
// Result register: holds a finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module tws_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  tws_pkg::result_t result,
  output logic             take,
  output logic             out_valid,
  input  logic             out_stall,
  output tws_pkg::result_t out_result
);
  import tws_pkg::*;

  assign take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item_valid) begin
      out_result <= result;
    end
  end

endmodule

### rtl/core/three_wire_serial_master_top.sv
// ----------------------------------------------------------------------------
// three_wire_serial_master_top
// Bus master for a three-wire real-time clock link, one item per half
// period of the serial clock.
// Path from input transfer to result: the input register, then one pass
// of the state machine into the result register.
// Throughput: one item per cycle without stalls; one state update per item.
// Reset: synchronous; engine lines low, phase idle, both channels empty.
// ----------------------------------------------------------------------------
module three_wire_serial_master_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] command_byte,
  input  logic [7:0] write_data,
  input  logic       sda_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       chip_enable,
  output logic       serial_clock,
  output logic       sda_out,
  output logic       sda_drive,
  output logic       busy_res,
  output logic       read_valid,
  output logic [7:0] read_data
);
  import tws_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  result_t result;
  result_t out_result;

  assign in_item.action       = action;
  assign in_item.command_byte = command_byte;
  assign in_item.write_data   = write_data;
  assign in_item.sda_in       = sda_in;

  tws_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  tws_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (item_valid && take),
    .item   (item),
    .result (result)
  );

  tws_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .result     (result),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign chip_enable  = out_result.chip_enable;
  assign serial_clock = out_result.serial_clock;
  assign sda_out      = out_result.sda_out;
  assign sda_drive    = out_result.sda_drive;
  assign busy_res     = out_result.busy_res;
  assign read_valid   = out_result.read_valid;
  assign read_data    = out_result.read_data;

endmodule

### rtl/core/tws_checker.sv
// ----------------------------------------------------------------------------
// tws_checker
// Port-level checks for the three-wire serial master, bound to the top.
// ----------------------------------------------------------------------------
module tws_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       chip_enable,
  input logic       serial_clock,
  input logic       sda_out,
  input logic       sda_drive,
  input logic       busy_res,
  input logic       read_valid,
  input logic [7:0] read_data
);

  // enable is high exactly while a transaction runs
  a_busy_ce: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (busy_res == chip_enable))
    else $error("busy and chip enable disagree");

  // a completed read leaves the link idle with the clock high
  a_read_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_valid |-> !busy_res && serial_clock && !sda_drive)
    else $error("read completion with link not idle");

  // data line is low whenever the master does not drive it
  a_no_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sda_drive |-> !sda_out)
    else $error("sda_out high while released");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(read_valid))
    else $error("stalled result changed");

  // the input only backs up behind a stalled, full result register
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room downstream");

endmodule

bind three_wire_serial_master_top tws_checker u_tws_checker (.*);

### tb/tws_link_checker.sv
// ----------------------------------------------------------------------------
// tws_link_checker
// Watches both channels of the three-wire serial master, predicts the line
// levels and read byte for every input transfer, and compares each output
// transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tws_link_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] command_byte,
  input  logic [7:0] write_data,
  input  logic       sda_in,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       chip_enable,
  input  logic       serial_clock,
  input  logic       sda_out,
  input  logic       sda_drive,
  input  logic       busy_res,
  input  logic       read_valid,
  input  logic [7:0] read_data,
  output int         mismatches,
  output int         awaiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import tws_pkg::*;

  // predictor state
  phase_t             ph;
  logic [CNT_W-1:0]   bit_cnt;
  logic               clk_high;
  logic [7:0]         tx_byte;
  logic [7:0]         held_data;
  logic [7:0]         rx_byte;
  logic               read_txn;
  logic               ce_lvl;
  logic               sck_lvl;
  logic               dat_lvl;

  result_t            predicted_lines[$];

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  task automatic clear_link();
    ph        = PH_IDLE;
    bit_cnt   = '0;
    clk_high  = 1'b0;
    tx_byte   = 8'h00;
    held_data = 8'h00;
    rx_byte   = 8'h00;
    read_txn  = 1'b0;
    ce_lvl    = 1'b0;
    sck_lvl   = 1'b0;
    dat_lvl   = 1'b0;
  endtask

  // clock low, next bit of the outgoing byte on the data line
  task automatic drive_next_bit();
    sck_lvl  = 1'b0;
    dat_lvl  = tx_byte[0];
    clk_high = 1'b0;
  endtask

  // clock low, data line level shifts into the top of the receive byte
  task automatic take_bit(input logic level);
    sck_lvl  = 1'b0;
    rx_byte  = {level, rx_byte[7:1]};
    bit_cnt  = bit_cnt + 1'b1;
    clk_high = 1'b0;
  endtask

  task automatic close_txn();
    sck_lvl  = 1'b1;
    ce_lvl   = 1'b0;
    ph       = PH_IDLE;
    clk_high = 1'b0;
    bit_cnt  = '0;
  endtask

  function automatic logic is_start(input logic [1:0] a);
    return (a == ACT_WRITE) || (a == ACT_READ);
  endfunction

  task automatic step_link(input item_t it, output result_t r);
    logic done_rd;
    logic drv;
    done_rd = 1'b0;
    if (ph == PH_IDLE) begin
      if (is_start(it.action)) begin
        read_txn  = (it.action == ACT_READ);
        held_data = it.write_data;
        tx_byte   = it.command_byte;
        rx_byte   = 8'h00;
        bit_cnt   = '0;
        ph        = PH_CMD;
        ce_lvl    = 1'b1;
        drive_next_bit();
      end
    end else if (ph == PH_CMD || ph == PH_WDATA) begin
      if (!clk_high) begin
        sck_lvl  = 1'b1;
        clk_high = 1'b1;
        bit_cnt  = bit_cnt + 1'b1;
      end else if (bit_cnt < BITS_PER_BYTE) begin
        tx_byte = tx_byte >> 1;
        drive_next_bit();
      end else if (ph == PH_CMD && !read_txn) begin
        ph      = PH_WDATA;
        tx_byte = held_data;
        bit_cnt = '0;
        drive_next_bit();
      end else if (ph == PH_CMD) begin
        // turn the line around, first sample on this same clock fall
        ph      = PH_RDATA;
        bit_cnt = '0;
        dat_lvl = 1'b0;
        take_bit(it.sda_in);
      end else begin
        close_txn();
      end
    end else begin
      if (clk_high) begin
        take_bit(it.sda_in);
      end else if (bit_cnt >= BITS_PER_BYTE) begin
        close_txn();
        done_rd = 1'b1;
      end else begin
        sck_lvl  = 1'b1;
        clk_high = 1'b1;
      end
    end
    drv            = (ph == PH_CMD) || (ph == PH_WDATA);
    r.chip_enable  = ce_lvl;
    r.serial_clock = sck_lvl;
    r.sda_out      = drv & dat_lvl;
    r.sda_drive    = drv;
    r.busy_res     = (ph != PH_IDLE);
    r.read_valid   = done_rd;
    r.read_data    = rx_byte;
  endtask

  always @(posedge clk) begin
    item_t   it;
    result_t want;
    if (rst) begin
      clear_link();
      predicted_lines.delete();
    end else begin
      if (in_valid && !in_stall) begin
        it.action       = action;
        it.command_byte = command_byte;
        it.write_data   = write_data;
        it.sda_in       = sda_in;
        step_link(it, want);
        predicted_lines.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (predicted_lines.size() == 0) begin
          flag_mismatch("result with nothing pending", read_data, 8'h00);
        end else begin
          want = predicted_lines.pop_front();
          if (chip_enable !== want.chip_enable)
            flag_mismatch("chip_enable", chip_enable, want.chip_enable);
          if (serial_clock !== want.serial_clock)
            flag_mismatch("serial_clock", serial_clock, want.serial_clock);
          if (sda_out !== want.sda_out)
            flag_mismatch("sda_out", sda_out, want.sda_out);
          if (sda_drive !== want.sda_drive)
            flag_mismatch("sda_drive", sda_drive, want.sda_drive);
          if (busy_res !== want.busy_res)
            flag_mismatch("busy_res", busy_res, want.busy_res);
          if (read_valid !== want.read_valid)
            flag_mismatch("read_valid", read_valid, want.read_valid);
          if (read_data !== want.read_data)
            flag_mismatch("read_data", read_data, want.read_data);
        end
      end
    end
    awaiting = predicted_lines.size();
  end

endmodule

### tb/tb_three_wire_serial_master_top.sv
// ----------------------------------------------------------------------------
// tb_three_wire_serial_master_top
// Drives write and read transactions, half a serial clock period per
// transfer, into the three-wire serial master with random gaps and output
// stalls, and takes the verdict from the link checker.
// ----------------------------------------------------------------------------
module tb_three_wire_serial_master_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tws_pkg::*;

  // action code with no meaning of its own, acts as a tick
  localparam logic [1:0] ACT_SPARE = 2'd3;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] action;
  logic [7:0] command_byte;
  logic [7:0] write_data;
  logic       sda_in;
  logic       out_valid;
  logic       out_stall;
  logic       chip_enable;
  logic       serial_clock;
  logic       sda_out;
  logic       sda_drive;
  logic       busy_res;
  logic       read_valid;
  logic [7:0] read_data;

  int         mismatches;
  int         awaiting;
  int         sent = 0;
  bit         tx_gaps_on = 1'b1;
  bit         rx_calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  three_wire_serial_master_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .command_byte (command_byte),
    .write_data   (write_data),
    .sda_in       (sda_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .chip_enable  (chip_enable),
    .serial_clock (serial_clock),
    .sda_out      (sda_out),
    .sda_drive    (sda_drive),
    .busy_res     (busy_res),
    .read_valid   (read_valid),
    .read_data    (read_data)
  );

  tws_link_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .command_byte (command_byte),
    .write_data   (write_data),
    .sda_in       (sda_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .chip_enable  (chip_enable),
    .serial_clock (serial_clock),
    .sda_out      (sda_out),
    .sda_drive    (sda_drive),
    .busy_res     (busy_res),
    .read_valid   (read_valid),
    .read_data    (read_data),
    .mismatches   (mismatches),
    .awaiting     (awaiting)
  );

  // one half-period transfer; returns at the edge that accepts it
  task automatic send_item(input logic [1:0] act, input logic [7:0] cmd,
                           input logic [7:0] wd, input logic sd);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    command_byte <= cmd;
    write_data   <= wd;
    sda_in       <= sd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // receiver: random stalls, calm stretches, and two long hold-offs
  initial begin
    int hold;
    int got;
    got = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (got % 50 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      if (got == 300 || got == 1100) hold = 200;
      else if (rx_calm) hold = 0;
      else hold = $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got++;
    end
  end

  initial begin
    int         i;
    int         n;
    logic [1:0] kind;
    logic [1:0] act;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    action       <= ACT_TICK;
    command_byte <= 8'h00;
    write_data   <= 8'h00;
    sda_in       <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // idle: a tick and the spare code leave the lines where they are
    send_item(ACT_TICK, 8'h00, 8'h00, 1'b0);
    send_item(ACT_SPARE, 8'hFF, 8'hFF, 1'b1);
    // all-ones command, zero data; starts offered mid-transaction are ignored
    send_item(ACT_WRITE, 8'hFF, 8'h00, 1'b0);
    for (i = 0; i < 32; i++) begin
      act = (i == 3) ? ACT_READ : (i == 20) ? ACT_WRITE : (i == 25) ? ACT_SPARE : ACT_TICK;
      send_item(act, 8'h5A, 8'hA5, 1'b1);
    end
    // zero command read with the data line held high
    send_item(ACT_READ, 8'h00, 8'hFF, 1'b0);
    for (i = 0; i < 32; i++) send_item(ACT_TICK, 8'h00, 8'h00, 1'b1);

    while (sent < 1650) begin
      tx_gaps_on = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 7) != 0) begin
        kind = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
        send_item(kind, 8'($urandom), 8'($urandom), 1'($urandom));
        n = 32 + $urandom_range(0, 3);
        for (i = 0; i < n; i++) begin
          act = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(ACT_WRITE, ACT_SPARE))
                                             : ACT_TICK;
          send_item(act, 8'($urandom), 8'($urandom), 1'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(2'($urandom_range(ACT_TICK, ACT_SPARE)), 8'($urandom), 8'($urandom),
                    1'($urandom));
      end
    end
    in_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_three_wire_serial_master_top OK");
    end else begin
      $display("tb_three_wire_serial_master_top NOT OK");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_three_wire_serial_master_top NOT OK");
    $finish;
  end

endmodule
